// ----- sv/rtc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

	// Datapath word: signed Q16.16
	localparam int COORD_W = 32;
	localparam int IDX_W = 16;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int THR_W = 31;
	localparam int ACC_W = COORD_W + 3;
	localparam int SAT_W = COORD_W + 16;
	localparam int DIV_STEPS = SAT_W;
	localparam int MAX_TRIANGLES_DEF = 65536;
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_TEST_LAST = STEP_W'(23);
	localparam logic [STEP_W-1:0] STEP_PNT_FIRST = STEP_W'(24);
	localparam logic [STEP_W-1:0] STEP_PNT_LAST = STEP_W'(29);

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	// 9999.0 in Q16.16
	localparam coord_t T_LIMIT = COORD_W'(9999 * 65536);
	localparam coord_t C_ZERO = '0;

	typedef struct packed {
		coord_t v0_x;
		coord_t v0_y;
		coord_t v0_z;
		coord_t v1_x;
		coord_t v1_y;
		coord_t v1_z;
		coord_t v2_x;
		coord_t v2_y;
		coord_t v2_z;
		logic last_triangle;
	} in_word_t;

	typedef struct packed {
		logic found;
		coord_t hit_t;
		coord_t hit_u;
		coord_t hit_v;
		logic [IDX_W-1:0] hit_index;
		coord_t hit_point_x;
		coord_t hit_point_y;
		coord_t hit_point_z;
	} out_word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X,
		CFG_ORIGIN_Y,
		CFG_ORIGIN_Z,
		CFG_DIR_X,
		CFG_DIR_Y,
		CFG_DIR_Z,
		CFG_FIRST_HIT_MODE,
		CFG_DET_THRESHOLD
	} cfg_idx_t;

	// Multiplier operand sources
	typedef enum logic [4:0] {
		OP_DX, OP_DY, OP_DZ,
		OP_E1X, OP_E1Y, OP_E1Z,
		OP_E2X, OP_E2Y, OP_E2Z,
		OP_TVX, OP_TVY, OP_TVZ,
		OP_PV0, OP_PV1, OP_PV2,
		OP_QV0, OP_QV1, OP_QV2,
		OP_U, OP_V
	} opnd_t;

	// Accumulator write-back destinations
	typedef enum logic [3:0] {
		DST_NONE,
		DST_PV0, DST_PV1, DST_PV2,
		DST_DET, DST_UN,
		DST_QV0, DST_QV1, DST_QV2,
		DST_VN, DST_TN,
		DST_PT0, DST_PT1, DST_PT2
	} dest_t;

	typedef enum logic [1:0] {
		SEED_ZERO, SEED_V0X, SEED_V0Y, SEED_V0Z
	} seed_t;

	typedef enum logic [1:0] {
		DIV_T, DIV_U, DIV_V
	} div_sel_t;

	typedef struct packed {
		logic valid;
		opnd_t a;
		opnd_t b;
		logic first;
		logic sub;
		seed_t seed;
		dest_t dest;
	} mac_cmd_t;

	typedef struct packed {
		logic load;
		mac_cmd_t mac;
		logic div_start;
		div_sel_t div_sel;
		logic finish;
		logic hit;
	} ctl_cmd_t;

	typedef struct packed {
		logic batch_done;
		logic first_mode;
		logic last;
		logic pass;
		logic t_lt_best;
		logic div_done;
		logic out_free;
	} dp_status_t;

	// Magnitude of a signed word; the most negative value maps to 2^(W-1).
	function automatic logic [COORD_W-1:0] mag(input coord_t a);
		logic [COORD_W-1:0] r;
		r = a[COORD_W-1] ? COORD_W'(-a) : COORD_W'(a);
		return r;
	endfunction

	// Apply a sign to a magnitude and saturate to the datapath word.
	function automatic coord_t sat_mag(input logic neg, input logic [SAT_W-1:0] m);
		logic [COORD_W-1:0] lo;
		coord_t r;
		lo = m[COORD_W-1:0];
		if (neg) begin
			r = (m > SAT_W'(C_MAX)) ? C_MIN : coord_t'(-lo);
		end else begin
			r = (m > SAT_W'(C_MAX)) ? C_MAX : coord_t'(lo);
		end
		return r;
	endfunction

	// Saturate a wide signed sum to the datapath word.
	function automatic coord_t sat_sum(input logic signed [ACC_W-1:0] x);
		coord_t r;
		if (x > ACC_W'(C_MAX)) begin
			r = C_MAX;
		end else if (x < ACC_W'(C_MIN)) begin
			r = C_MIN;
		end else begin
			r = coord_t'(x[COORD_W-1:0]);
		end
		return r;
	endfunction

	function automatic coord_t sat_diff(input coord_t a, input coord_t b);
		logic signed [ACC_W-1:0] d;
		d = ACC_W'(a) - ACC_W'(b);
		return sat_sum(d);
	endfunction

	function automatic mac_cmd_t mk(input opnd_t a, input opnd_t b, input logic first,
			input logic sub, input seed_t seed, input dest_t dest);
		mac_cmd_t c;
		c.valid = 1'b1;
		c.a = a;
		c.b = b;
		c.first = first;
		c.sub = sub;
		c.seed = seed;
		c.dest = dest;
		return c;
	endfunction

	// Multiply-accumulate sequence: pv, det, un, qv, vn, tn, then the hit point.
	function automatic mac_cmd_t ucode(input logic [STEP_W-1:0] step);
		mac_cmd_t c;
		c = '0;
		case (step)
			5'd0: c = mk(OP_DY, OP_E2Z, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd1: c = mk(OP_DZ, OP_E2Y, 1'b0, 1'b1, SEED_ZERO, DST_PV0);
			5'd2: c = mk(OP_DZ, OP_E2X, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd3: c = mk(OP_DX, OP_E2Z, 1'b0, 1'b1, SEED_ZERO, DST_PV1);
			5'd4: c = mk(OP_DX, OP_E2Y, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd5: c = mk(OP_DY, OP_E2X, 1'b0, 1'b1, SEED_ZERO, DST_PV2);
			5'd6: c = mk(OP_E1X, OP_PV0, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd7: c = mk(OP_E1Y, OP_PV1, 1'b0, 1'b0, SEED_ZERO, DST_NONE);
			5'd8: c = mk(OP_E1Z, OP_PV2, 1'b0, 1'b0, SEED_ZERO, DST_DET);
			5'd9: c = mk(OP_TVX, OP_PV0, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd10: c = mk(OP_TVY, OP_PV1, 1'b0, 1'b0, SEED_ZERO, DST_NONE);
			5'd11: c = mk(OP_TVZ, OP_PV2, 1'b0, 1'b0, SEED_ZERO, DST_UN);
			5'd12: c = mk(OP_TVY, OP_E1Z, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd13: c = mk(OP_TVZ, OP_E1Y, 1'b0, 1'b1, SEED_ZERO, DST_QV0);
			5'd14: c = mk(OP_TVZ, OP_E1X, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd15: c = mk(OP_TVX, OP_E1Z, 1'b0, 1'b1, SEED_ZERO, DST_QV1);
			5'd16: c = mk(OP_TVX, OP_E1Y, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd17: c = mk(OP_TVY, OP_E1X, 1'b0, 1'b1, SEED_ZERO, DST_QV2);
			5'd18: c = mk(OP_DX, OP_QV0, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd19: c = mk(OP_DY, OP_QV1, 1'b0, 1'b0, SEED_ZERO, DST_NONE);
			5'd20: c = mk(OP_DZ, OP_QV2, 1'b0, 1'b0, SEED_ZERO, DST_VN);
			5'd21: c = mk(OP_E2X, OP_QV0, 1'b1, 1'b0, SEED_ZERO, DST_NONE);
			5'd22: c = mk(OP_E2Y, OP_QV1, 1'b0, 1'b0, SEED_ZERO, DST_NONE);
			5'd23: c = mk(OP_E2Z, OP_QV2, 1'b0, 1'b0, SEED_ZERO, DST_TN);
			5'd24: c = mk(OP_U, OP_E1X, 1'b1, 1'b0, SEED_V0X, DST_NONE);
			5'd25: c = mk(OP_V, OP_E2X, 1'b0, 1'b0, SEED_ZERO, DST_PT0);
			5'd26: c = mk(OP_U, OP_E1Y, 1'b1, 1'b0, SEED_V0Y, DST_NONE);
			5'd27: c = mk(OP_V, OP_E2Y, 1'b0, 1'b0, SEED_ZERO, DST_PT1);
			5'd28: c = mk(OP_U, OP_E1Z, 1'b1, 1'b0, SEED_V0Z, DST_NONE);
			5'd29: c = mk(OP_V, OP_E2Z, 1'b0, 1'b0, SEED_ZERO, DST_PT2);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/rtc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: (|num| << 16) / den, one quotient bit per cycle,
// then signed and saturated to the datapath word.
module rtc_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  rtc_pkg::coord_t     num,
	input  rtc_pkg::coord_t     den,
	output logic                done,
	output rtc_pkg::coord_t     quo
);

	localparam int CNT_W = $clog2(rtc_pkg::DIV_STEPS);
	localparam int W = rtc_pkg::COORD_W;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [rtc_pkg::SAT_W-1:0] work_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     den_q;
	logic             neg_q;
	rtc_pkg::coord_t  quo_q;

	logic [W:0]       trial;
	logic             ge;
	logic [W:0]       rem_sub;
	logic [rtc_pkg::SAT_W-1:0] work_next;

	// One trial subtraction per cycle
	always_comb begin
		trial = {rem_q, work_q[rtc_pkg::SAT_W-1]};
		ge = (trial >= {1'b0, den_q});
		rem_sub = trial - {1'b0, den_q};
		work_next = {work_q[rtc_pkg::SAT_W-2:0], ge};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(rtc_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands, remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= {rtc_pkg::mag(num), 16'b0};
			rem_q <= '0;
			den_q <= W'(den);
			neg_q <= num[W-1];
		end else if (busy_q) begin
			work_q <= work_next;
			rem_q <= ge ? rem_sub[W-1:0] : trial[W-1:0];
			if (cnt_q == CNT_W'(rtc_pkg::DIV_STEPS - 1)) begin
				quo_q <= rtc_pkg::sat_mag(neg_q, work_next);
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

`default_nettype wire

// ----- sv/rtc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Register file, shared multiply-accumulate pipeline, divider, batch state
// and the output register.
module rtc_datapath #(
	parameter int MAX_TRIANGLES = rtc_pkg::MAX_TRIANGLES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rtc_pkg::CFG_W-1:0]      cfg_data,
	input  rtc_pkg::in_word_t                   in_word,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output rtc_pkg::out_word_t                  out_word,
	input  rtc_pkg::ctl_cmd_t                   cmd,
	output rtc_pkg::dp_status_t                 status
);

	localparam int CNT_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int W = rtc_pkg::COORD_W;
	localparam int AW = rtc_pkg::ACC_W;

	// Configuration
	rtc_pkg::coord_t origin_x_q, origin_y_q, origin_z_q;
	rtc_pkg::coord_t dir_x_q, dir_y_q, dir_z_q;
	logic first_mode_q;
	logic [rtc_pkg::THR_W-1:0] thr_q;

	// Per-triangle registers
	rtc_pkg::coord_t v0x_q, v0y_q, v0z_q;
	rtc_pkg::coord_t e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	rtc_pkg::coord_t tvx_q, tvy_q, tvz_q;
	rtc_pkg::coord_t pv0_q, pv1_q, pv2_q, qv0_q, qv1_q, qv2_q;
	rtc_pkg::coord_t det_q, un_q, vn_q, tn_q;
	rtc_pkg::coord_t t_q, u_q, v_q;
	rtc_pkg::coord_t pt0_q, pt1_q, pt2_q;
	logic last_q;
	logic [CNT_W-1:0] idx_q;

	// Batch state
	rtc_pkg::coord_t best_t_q, best_u_q, best_v_q;
	rtc_pkg::coord_t best_p0_q, best_p1_q, best_p2_q;
	logic [CNT_W-1:0] best_idx_q;
	logic [CNT_W-1:0] count_q;
	logic any_hit_q;
	logic batch_done_q;

	// Output register
	logic out_valid_q;
	rtc_pkg::out_word_t out_word_q;

	// Multiply pipeline
	rtc_pkg::coord_t op_a, op_b;
	logic [2*W-1:0] prod_s1;
	logic neg_s1;
	rtc_pkg::mac_cmd_t mac_s1;
	logic signed [AW-1:0] acc_q;
	rtc_pkg::coord_t sprod;
	logic signed [AW-1:0] seed_ext;
	logic signed [AW-1:0] acc_base;
	logic signed [AW-1:0] acc_sum;
	rtc_pkg::coord_t acc_sat;

	// Divider
	rtc_pkg::coord_t div_num;
	logic div_done;
	rtc_pkg::coord_t div_quo;

	// Decisions
	logic [rtc_pkg::THR_W-1:0] thr_eff;
	logic signed [W:0] det_x, un_x, vn_x, uv_sum;
	logic [CNT_W:0] cnt_inc;
	logic [CNT_W-1:0] cnt_next;
	logic out_free;
	logic emit;
	rtc_pkg::out_word_t cur_word, best_word;

	// Operand selection for the multiplier
	always_comb begin
		case (cmd.mac.a)
			rtc_pkg::OP_DX:  op_a = dir_x_q;
			rtc_pkg::OP_DY:  op_a = dir_y_q;
			rtc_pkg::OP_DZ:  op_a = dir_z_q;
			rtc_pkg::OP_E1X: op_a = e1x_q;
			rtc_pkg::OP_E1Y: op_a = e1y_q;
			rtc_pkg::OP_E1Z: op_a = e1z_q;
			rtc_pkg::OP_E2X: op_a = e2x_q;
			rtc_pkg::OP_E2Y: op_a = e2y_q;
			rtc_pkg::OP_E2Z: op_a = e2z_q;
			rtc_pkg::OP_TVX: op_a = tvx_q;
			rtc_pkg::OP_TVY: op_a = tvy_q;
			rtc_pkg::OP_TVZ: op_a = tvz_q;
			rtc_pkg::OP_PV0: op_a = pv0_q;
			rtc_pkg::OP_PV1: op_a = pv1_q;
			rtc_pkg::OP_PV2: op_a = pv2_q;
			rtc_pkg::OP_QV0: op_a = qv0_q;
			rtc_pkg::OP_QV1: op_a = qv1_q;
			rtc_pkg::OP_QV2: op_a = qv2_q;
			rtc_pkg::OP_U:   op_a = u_q;
			rtc_pkg::OP_V:   op_a = v_q;
			default:         op_a = rtc_pkg::C_ZERO;
		endcase
		case (cmd.mac.b)
			rtc_pkg::OP_DX:  op_b = dir_x_q;
			rtc_pkg::OP_DY:  op_b = dir_y_q;
			rtc_pkg::OP_DZ:  op_b = dir_z_q;
			rtc_pkg::OP_E1X: op_b = e1x_q;
			rtc_pkg::OP_E1Y: op_b = e1y_q;
			rtc_pkg::OP_E1Z: op_b = e1z_q;
			rtc_pkg::OP_E2X: op_b = e2x_q;
			rtc_pkg::OP_E2Y: op_b = e2y_q;
			rtc_pkg::OP_E2Z: op_b = e2z_q;
			rtc_pkg::OP_TVX: op_b = tvx_q;
			rtc_pkg::OP_TVY: op_b = tvy_q;
			rtc_pkg::OP_TVZ: op_b = tvz_q;
			rtc_pkg::OP_PV0: op_b = pv0_q;
			rtc_pkg::OP_PV1: op_b = pv1_q;
			rtc_pkg::OP_PV2: op_b = pv2_q;
			rtc_pkg::OP_QV0: op_b = qv0_q;
			rtc_pkg::OP_QV1: op_b = qv1_q;
			rtc_pkg::OP_QV2: op_b = qv2_q;
			rtc_pkg::OP_U:   op_b = u_q;
			rtc_pkg::OP_V:   op_b = v_q;
			default:         op_b = rtc_pkg::C_ZERO;
		endcase
	end

	// Stage 1: unsigned product of the magnitudes
	always_ff @(posedge clk) begin
		prod_s1 <= rtc_pkg::mag(op_a) * rtc_pkg::mag(op_b);
		neg_s1 <= op_a[W-1] ^ op_b[W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= '0;
		end else begin
			mac_s1 <= cmd.mac;
		end
	end

	// Stage 2: scale, saturate and accumulate
	always_comb begin
		sprod = rtc_pkg::sat_mag(neg_s1, prod_s1[rtc_pkg::SAT_W+15:16]);
		case (mac_s1.seed)
			rtc_pkg::SEED_V0X: seed_ext = AW'(v0x_q);
			rtc_pkg::SEED_V0Y: seed_ext = AW'(v0y_q);
			rtc_pkg::SEED_V0Z: seed_ext = AW'(v0z_q);
			default:           seed_ext = '0;
		endcase
		acc_base = mac_s1.first ? seed_ext : acc_q;
		acc_sum = mac_s1.sub ? acc_base - AW'(sprod) : acc_base + AW'(sprod);
		acc_sat = rtc_pkg::sat_sum(acc_sum);
	end

	always_ff @(posedge clk) begin
		if (mac_s1.valid) begin
			acc_q <= acc_sum;
			case (mac_s1.dest)
				rtc_pkg::DST_PV0: pv0_q <= acc_sat;
				rtc_pkg::DST_PV1: pv1_q <= acc_sat;
				rtc_pkg::DST_PV2: pv2_q <= acc_sat;
				rtc_pkg::DST_DET: det_q <= acc_sat;
				rtc_pkg::DST_UN:  un_q <= acc_sat;
				rtc_pkg::DST_QV0: qv0_q <= acc_sat;
				rtc_pkg::DST_QV1: qv1_q <= acc_sat;
				rtc_pkg::DST_QV2: qv2_q <= acc_sat;
				rtc_pkg::DST_VN:  vn_q <= acc_sat;
				rtc_pkg::DST_TN:  tn_q <= acc_sat;
				rtc_pkg::DST_PT0: pt0_q <= acc_sat;
				rtc_pkg::DST_PT1: pt1_q <= acc_sat;
				rtc_pkg::DST_PT2: pt2_q <= acc_sat;
				default: ;
			endcase
		end
	end

	// Divider and quotient write-back
	always_comb begin
		case (cmd.div_sel)
			rtc_pkg::DIV_U: div_num = un_q;
			rtc_pkg::DIV_V: div_num = vn_q;
			default:        div_num = tn_q;
		endcase
	end

	rtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_sel)
				rtc_pkg::DIV_U: u_q <= div_quo;
				rtc_pkg::DIV_V: v_q <= div_quo;
				default:        t_q <= div_quo;
			endcase
		end
	end

	// Triangle load: first vertex, edges, origin offset, last flag and index
	always_ff @(posedge clk) begin
		if (cmd.load && !batch_done_q) begin
			v0x_q <= in_word.v0_x;
			v0y_q <= in_word.v0_y;
			v0z_q <= in_word.v0_z;
			e1x_q <= rtc_pkg::sat_diff(in_word.v1_x, in_word.v0_x);
			e1y_q <= rtc_pkg::sat_diff(in_word.v1_y, in_word.v0_y);
			e1z_q <= rtc_pkg::sat_diff(in_word.v1_z, in_word.v0_z);
			e2x_q <= rtc_pkg::sat_diff(in_word.v2_x, in_word.v0_x);
			e2y_q <= rtc_pkg::sat_diff(in_word.v2_y, in_word.v0_y);
			e2z_q <= rtc_pkg::sat_diff(in_word.v2_z, in_word.v0_z);
			tvx_q <= rtc_pkg::sat_diff(origin_x_q, in_word.v0_x);
			tvy_q <= rtc_pkg::sat_diff(origin_y_q, in_word.v0_y);
			tvz_q <= rtc_pkg::sat_diff(origin_z_q, in_word.v0_z);
			last_q <= in_word.last_triangle;
			idx_q <= count_q;
		end
	end

	// Hit test on the finished sums
	always_comb begin
		thr_eff = (thr_q == '0) ? rtc_pkg::THR_W'(1) : thr_q;
		det_x = (W+1)'(det_q);
		un_x = (W+1)'(un_q);
		vn_x = (W+1)'(vn_q);
		uv_sum = un_x + vn_x;
		status.pass = (det_x >= $signed({2'b00, thr_eff})) && !un_q[W-1] &&
			(un_x <= det_x) && !vn_q[W-1] && (uv_sum <= det_x);
		status.t_lt_best = (t_q < best_t_q);
		status.div_done = div_done;
		status.batch_done = batch_done_q;
		status.first_mode = first_mode_q;
		status.last = last_q;
		status.out_free = out_free;
	end

	// Result words for the current triangle and for the batch best
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		emit = last_q || (cmd.hit && first_mode_q);
		cnt_inc = {1'b0, count_q} + (CNT_W+1)'(1);
		cnt_next = (cnt_inc >= (CNT_W+1)'(MAX_TRIANGLES)) ? '0 : cnt_inc[CNT_W-1:0];

		cur_word.found = 1'b1;
		cur_word.hit_t = t_q;
		cur_word.hit_u = u_q;
		cur_word.hit_v = v_q;
		cur_word.hit_index = rtc_pkg::IDX_W'(idx_q);
		cur_word.hit_point_x = pt0_q;
		cur_word.hit_point_y = pt1_q;
		cur_word.hit_point_z = pt2_q;

		best_word = '0;
		if (any_hit_q) begin
			best_word.found = 1'b1;
			best_word.hit_t = best_t_q;
			best_word.hit_u = best_u_q;
			best_word.hit_v = best_v_q;
			best_word.hit_index = rtc_pkg::IDX_W'(best_idx_q);
			best_word.hit_point_x = best_p0_q;
			best_word.hit_point_y = best_p1_q;
			best_word.hit_point_z = best_p2_q;
		end
	end

	// Configuration, batch state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			dir_x_q <= '0;
			dir_y_q <= '0;
			dir_z_q <= rtc_pkg::COORD_W'(65536);
			first_mode_q <= 1'b0;
			thr_q <= rtc_pkg::THR_W'(7);
			best_t_q <= rtc_pkg::T_LIMIT;
			best_u_q <= '0;
			best_v_q <= '0;
			best_p0_q <= '0;
			best_p1_q <= '0;
			best_p2_q <= '0;
			best_idx_q <= '0;
			count_q <= '0;
			any_hit_q <= 1'b0;
			batch_done_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_word_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (rtc_pkg::cfg_idx_t'(cfg_index))
					rtc_pkg::CFG_ORIGIN_X: origin_x_q <= rtc_pkg::coord_t'(cfg_data);
					rtc_pkg::CFG_ORIGIN_Y: origin_y_q <= rtc_pkg::coord_t'(cfg_data);
					rtc_pkg::CFG_ORIGIN_Z: origin_z_q <= rtc_pkg::coord_t'(cfg_data);
					rtc_pkg::CFG_DIR_X: dir_x_q <= rtc_pkg::coord_t'(cfg_data);
					rtc_pkg::CFG_DIR_Y: dir_y_q <= rtc_pkg::coord_t'(cfg_data);
					rtc_pkg::CFG_DIR_Z: dir_z_q <= rtc_pkg::coord_t'(cfg_data);
					rtc_pkg::CFG_FIRST_HIT_MODE: first_mode_q <= cfg_data[0];
					rtc_pkg::CFG_DET_THRESHOLD: thr_q <= cfg_data[rtc_pkg::THR_W-1:0];
				endcase
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.load) begin
				if (batch_done_q) begin
					// Rest of a batch after a first-hit report: only the end counts
					if (in_word.last_triangle) begin
						batch_done_q <= 1'b0;
						count_q <= '0;
					end
				end else begin
					count_q <= cnt_next;
				end
			end

			if (cmd.finish) begin
				if (emit) begin
					out_valid_q <= 1'b1;
					out_word_q <= cmd.hit ? cur_word : best_word;
				end
				if (cmd.hit && !first_mode_q) begin
					best_t_q <= t_q;
					best_u_q <= u_q;
					best_v_q <= v_q;
					best_idx_q <= idx_q;
					best_p0_q <= pt0_q;
					best_p1_q <= pt1_q;
					best_p2_q <= pt2_q;
					any_hit_q <= 1'b1;
				end
				if (cmd.hit && first_mode_q && !last_q) begin
					batch_done_q <= 1'b1;
				end
				// End of batch: back to the reset state
				if (last_q) begin
					best_t_q <= rtc_pkg::T_LIMIT;
					best_u_q <= '0;
					best_v_q <= '0;
					best_idx_q <= '0;
					best_p0_q <= '0;
					best_p1_q <= '0;
					best_p2_q <= '0;
					count_q <= '0;
					any_hit_q <= 1'b0;
					batch_done_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	// A word without a hit carries zeros in every field.
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_word_q.found) |-> (out_word_q == '0))
		else $error("result without a hit has nonzero fields");

	// A result is only loaded when the output register can take it.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && emit) |-> out_free)
		else $error("result loaded over a waiting word");

	// The triangle counter stays below the batch wrap length.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} < (CNT_W+1)'(MAX_TRIANGLES)))
		else $error("triangle counter out of range");

endmodule

`default_nettype wire

// ----- sv/rtc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: walks the multiply-accumulate steps, runs the three divisions
// and closes each triangle.
module rtc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  rtc_pkg::dp_status_t  status,
	output rtc_pkg::ctl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_TEST,
		S_DIV_GO,
		S_DIV_WAIT,
		S_HITCHK,
		S_PNT,
		S_PDRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic [rtc_pkg::STEP_W-1:0] step_q;
	rtc_pkg::div_sel_t div_sel_q;
	logic hit_q;
	logic emit;

	// Commands decoded from the state
	always_comb begin
		cmd = '0;
		emit = status.last || (hit_q && status.first_mode);
		in_stall = (state_q != S_IDLE);
		cmd.div_sel = div_sel_q;
		cmd.hit = hit_q;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_MAC, S_PNT: cmd.mac = rtc_pkg::ucode(step_q);
			S_DIV_GO: cmd.div_start = 1'b1;
			S_FINISH: cmd.finish = !emit || status.out_free;
			S_DRAIN, S_TEST, S_DIV_WAIT, S_HITCHK, S_PDRAIN: ;
		endcase
	end

	// State and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			div_sel_q <= rtc_pkg::DIV_T;
			hit_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !status.batch_done) begin
						step_q <= '0;
						hit_q <= 1'b0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					step_q <= step_q + rtc_pkg::STEP_W'(1);
					if (step_q == rtc_pkg::STEP_TEST_LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_TEST;
				S_TEST: begin
					if (status.pass) begin
						div_sel_q <= rtc_pkg::DIV_T;
						state_q <= S_DIV_GO;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (status.div_done) begin
						unique case (div_sel_q)
							rtc_pkg::DIV_T: begin
								div_sel_q <= rtc_pkg::DIV_U;
								state_q <= S_DIV_GO;
							end
							rtc_pkg::DIV_U: begin
								div_sel_q <= rtc_pkg::DIV_V;
								state_q <= S_DIV_GO;
							end
							default: state_q <= S_HITCHK;
						endcase
					end
				end
				S_HITCHK: begin
					if (status.t_lt_best) begin
						step_q <= rtc_pkg::STEP_PNT_FIRST;
						state_q <= S_PNT;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_PNT: begin
					step_q <= step_q + rtc_pkg::STEP_W'(1);
					if (step_q == rtc_pkg::STEP_PNT_LAST) begin
						hit_q <= 1'b1;
						state_q <= S_PDRAIN;
					end
				end
				S_PDRAIN: state_q <= S_FINISH;
				S_FINISH: begin
					if (!emit || status.out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/ray_triangle_closest_hit_unit.sv -----
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  in_word (three vertices, last flag)
// out       output     out_valid/out_stall out_word (found, t, u, v, index, point)
// cfg       input      cfg_wr_en          cfg_index, cfg_data (no read-back)
//
// One triangle at a time: a triangle that passes the determinant and
// barycentric test runs three 48-step serial divisions, which a failing one
// skips; one multiplier is shared.
// After a first-hit report the rest of the batch is taken at one per cycle.
// Asynchronous active-low reset restores the register defaults and an empty batch.
// A result waits in the output register; a stalled output holds back only a
// triangle that must itself report.
`timescale 1ns / 1ps
`default_nettype none

module ray_triangle_closest_hit_unit #(
	parameter int MAX_TRIANGLES = rtc_pkg::MAX_TRIANGLES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  rtc_pkg::in_word_t                   in_word,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output rtc_pkg::out_word_t                  out_word,
	input  wire logic                           cfg_wr_en,
	input  wire logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rtc_pkg::CFG_W-1:0]      cfg_data
);

	rtc_pkg::ctl_cmd_t   cmd;
	rtc_pkg::dp_status_t status;

	rtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rtc_datapath #(
		.MAX_TRIANGLES (MAX_TRIANGLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

// ----- sim/rtc_checker.sv -----
`timescale 1ns / 1ps

// Watches the triangle and result channels of the closest-hit unit, keeps its
// own model of the ray registers and of the batch, and checks every reported word.
module rtc_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  rtc_pkg::in_word_t                  in_word,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  rtc_pkg::out_word_t                 out_word,
	input  wire logic                          cfg_wr_en,
	input  wire logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rtc_pkg::CFG_W-1:0]     cfg_data,
	output int                                 fails,
	output int                                 outstanding,
	output int                                 reports
);
	import rtc_pkg::*;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam longint T_MAX = 64'sd9999 * 64'sd65536;

	// Ray registers as the block should hold them.
	longint ray_org[3];
	longint ray_dir[3];
	bit first_mode;
	longint det_min;

	// Nearest hit of the batch so far.
	longint near_t, near_u, near_v;
	longint near_pt[3];
	int unsigned near_idx;
	int unsigned tri_count;
	bit got_hit;
	bit skipping;

	out_word_t hits_due[$];

	function automatic longint clamp_w(input longint x);
		if (x > WMAX) return WMAX;
		if (x < WMIN) return WMIN;
		return x;
	endfunction

	// Apply a sign to a magnitude and saturate to the word.
	function automatic longint signed_clamp(input bit neg, input longint unsigned m);
		if (neg) return (m > 64'd2147483648) ? WMIN : -longint'(m);
		return (m > 64'd2147483647) ? WMAX : longint'(m);
	endfunction

	function automatic longint unsigned magn(input longint a);
		return (a < 0) ? longint'(-a) : a;
	endfunction

	// Q16.16 product, truncated toward zero.
	function automatic longint fx_mul(input longint a, input longint b);
		longint unsigned m;
		m = (magn(a) * magn(b)) >> 16;
		return signed_clamp((a < 0) != (b < 0), m);
	endfunction

	// Q16.16 quotient with a positive divisor, truncated toward zero.
	function automatic longint fx_div(input longint n, input longint d);
		longint unsigned m;
		m = (magn(n) << 16) / longint'(d);
		return signed_clamp(n < 0, m);
	endfunction

	function automatic longint fx_dot(input longint a[3], input longint b[3]);
		return clamp_w(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]));
	endfunction

	function automatic void fx_cross(input longint a[3], input longint b[3],
			output longint r[3]);
		r[0] = clamp_w(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
		r[1] = clamp_w(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
		r[2] = clamp_w(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
	endfunction

	function automatic void clear_batch();
		near_t = T_MAX;
		near_u = 0;
		near_v = 0;
		near_idx = 0;
		near_pt = '{0, 0, 0};
		tri_count = 0;
		got_hit = 1'b0;
		skipping = 1'b0;
	endfunction

	function automatic out_word_t pack_hit(input bit f, input longint t, input longint u,
			input longint v, input int unsigned idx, input longint p[3]);
		out_word_t r;
		r = '0;
		if (f) begin
			r.found = 1'b1;
			r.hit_t = coord_t'(t);
			r.hit_u = coord_t'(u);
			r.hit_v = coord_t'(v);
			r.hit_index = IDX_W'(idx);
			r.hit_point_x = coord_t'(p[0]);
			r.hit_point_y = coord_t'(p[1]);
			r.hit_point_z = coord_t'(p[2]);
		end
		return r;
	endfunction

	// Runs one triangle through the test; returns 1 when it causes a report.
	function automatic bit test_triangle(input in_word_t w, output out_word_t r);
		longint p0[3], p1[3], p2[3], e1[3], e2[3], tv[3], pv[3], qv[3], pt[3];
		longint det, un, vn, tn, t, u, v;
		int unsigned idx;
		bit hit;
		r = '0;
		hit = 1'b0;
		t = 0;
		u = 0;
		v = 0;
		if (skipping) begin
			if (w.last_triangle) clear_batch();
			return 1'b0;
		end
		idx = tri_count;
		tri_count = (tri_count + 1 >= MAX_TRIANGLES_DEF) ? 0 : tri_count + 1;
		p0 = '{longint'(w.v0_x), longint'(w.v0_y), longint'(w.v0_z)};
		p1 = '{longint'(w.v1_x), longint'(w.v1_y), longint'(w.v1_z)};
		p2 = '{longint'(w.v2_x), longint'(w.v2_y), longint'(w.v2_z)};
		for (int k = 0; k < 3; k++) begin
			e1[k] = clamp_w(p1[k] - p0[k]);
			e2[k] = clamp_w(p2[k] - p0[k]);
			tv[k] = clamp_w(ray_org[k] - p0[k]);
		end
		fx_cross(ray_dir, e2, pv);
		det = fx_dot(e1, pv);
		// A determinant of zero or below never passes, whatever the threshold.
		if (det >= ((det_min < 1) ? 1 : det_min)) begin
			un = fx_dot(tv, pv);
			if (un >= 0 && un <= det) begin
				fx_cross(tv, e1, qv);
				vn = fx_dot(ray_dir, qv);
				if (vn >= 0 && un + vn <= det) begin
					tn = fx_dot(e2, qv);
					t = fx_div(tn, det);
					u = fx_div(un, det);
					v = fx_div(vn, det);
					hit = t < near_t;
				end
			end
		end
		if (hit) begin
			for (int k = 0; k < 3; k++)
				pt[k] = clamp_w(p0[k] + fx_mul(u, e1[k]) + fx_mul(v, e2[k]));
			if (first_mode) begin
				r = pack_hit(1'b1, t, u, v, idx, pt);
				if (w.last_triangle) clear_batch();
				else skipping = 1'b1;
				return 1'b1;
			end
			near_t = t;
			near_u = u;
			near_v = v;
			near_idx = idx;
			near_pt = pt;
			got_hit = 1'b1;
		end
		if (w.last_triangle) begin
			r = pack_hit(got_hit, near_t, near_u, near_v, near_idx, near_pt);
			clear_batch();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	// Register writes first, then the result word, then a new triangle word.
	always @(posedge clk or negedge arst_n) begin
		out_word_t want, res;
		if (!arst_n) begin
			ray_org = '{0, 0, 0};
			ray_dir = '{0, 0, 65536};
			first_mode = 1'b0;
			det_min = 7;
			clear_batch();
			hits_due.delete();
			fails = 0;
			outstanding = 0;
			reports = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ORIGIN_X: ray_org[0] = longint'($signed(cfg_data));
					CFG_ORIGIN_Y: ray_org[1] = longint'($signed(cfg_data));
					CFG_ORIGIN_Z: ray_org[2] = longint'($signed(cfg_data));
					CFG_DIR_X: ray_dir[0] = longint'($signed(cfg_data));
					CFG_DIR_Y: ray_dir[1] = longint'($signed(cfg_data));
					CFG_DIR_Z: ray_dir[2] = longint'($signed(cfg_data));
					CFG_FIRST_HIT_MODE: first_mode = cfg_data[0];
					CFG_DET_THRESHOLD: det_min = longint'(cfg_data[THR_W-1:0]);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				reports++;
				if (hits_due.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got %h",
						$time, out_word);
					fails++;
				end else begin
					want = hits_due.pop_front();
					check_field("found", want.found, out_word.found);
					check_field("hit_t", want.hit_t, out_word.hit_t);
					check_field("hit_u", want.hit_u, out_word.hit_u);
					check_field("hit_v", want.hit_v, out_word.hit_v);
					check_field("hit_index", want.hit_index, out_word.hit_index);
					check_field("hit_point_x", want.hit_point_x, out_word.hit_point_x);
					check_field("hit_point_y", want.hit_point_y, out_word.hit_point_y);
					check_field("hit_point_z", want.hit_point_z, out_word.hit_point_z);
				end
			end
			if (in_valid && !in_stall) begin
				if (test_triangle(in_word, res)) hits_due.push_back(res);
			end
			outstanding = hits_due.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import rtc_pkg::*;

	localparam int UNIT = 65536;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_word;
	logic out_valid;
	logic out_stall;
	out_word_t out_word;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int fails;
	int outstanding;
	int reports;
	int sent;
	bit quiet;
	bit hold_req;
	longint ray_o[3];
	longint ray_d[3];

	ray_triangle_closest_hit_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	rtc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .outstanding(outstanding), .reports(reports)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: random stalls, or a long hold-off when one is asked for.
	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold == 0) begin
				hold = 400;
				hold_req = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 7);
			end
		end
	end

	initial begin
		#30_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic coord_t clip(input longint x);
		if (x > 64'sd2147483647) return coord_t'(32'sh7FFFFFFF);
		if (x < -64'sd2147483648) return coord_t'(32'sh80000000);
		return coord_t'(x);
	endfunction

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait until every report is in, then give a failing triangle time to finish.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic set_ray(input longint o[3], input longint d[3]);
		cfg_write(CFG_ORIGIN_X, o[0][31:0]);
		cfg_write(CFG_ORIGIN_Y, o[1][31:0]);
		cfg_write(CFG_ORIGIN_Z, o[2][31:0]);
		cfg_write(CFG_DIR_X, d[0][31:0]);
		cfg_write(CFG_DIR_Y, d[1][31:0]);
		cfg_write(CFG_DIR_Z, d[2][31:0]);
		ray_o = o;
		ray_d = d;
	endtask

	task automatic send(input in_word_t w);
		if (!quiet && $urandom_range(99) < 7) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// A triangle around the point s units along the ray, wound either way.
	function automatic in_word_t aimed(input int s, input bit lst);
		in_word_t w;
		longint p[3], a[3], b[3], c[3];
		int dom, ax1, ax2;
		dom = 0;
		for (int k = 1; k < 3; k++)
			if ((ray_d[k] < 0 ? -ray_d[k] : ray_d[k]) > (ray_d[dom] < 0 ? -ray_d[dom] : ray_d[dom]))
				dom = k;
		ax1 = (dom + 1) % 3;
		ax2 = (dom + 2) % 3;
		for (int k = 0; k < 3; k++) begin
			p[k] = ray_o[k] + longint'(s) * ray_d[k];
			a[k] = p[k] + $signed($urandom_range(UNIT / 2)) - UNIT / 4;
			b[k] = a[k];
			c[k] = a[k];
		end
		a[ax1] = p[ax1] - $urandom_range(8 * UNIT, UNIT / 8);
		a[ax2] = p[ax2] - $urandom_range(8 * UNIT, UNIT / 8);
		b[ax1] = p[ax1] + $urandom_range(16 * UNIT, UNIT / 8);
		b[ax2] = a[ax2];
		c[ax1] = a[ax1];
		c[ax2] = p[ax2] + $urandom_range(16 * UNIT, UNIT / 8);
		if ($urandom_range(1)) begin
			p = b;
			b = c;
			c = p;
		end
		w.v0_x = clip(a[0]); w.v0_y = clip(a[1]); w.v0_z = clip(a[2]);
		w.v1_x = clip(b[0]); w.v1_y = clip(b[1]); w.v1_z = clip(b[2]);
		w.v2_x = clip(c[0]); w.v2_y = clip(c[1]); w.v2_z = clip(c[2]);
		w.last_triangle = lst;
		return w;
	endfunction

	// Either a small triangle near the origin or one with every bit at random.
	function automatic in_word_t noise(input bit wide, input bit lst);
		in_word_t w;
		logic [COORD_W-1:0] r[9];
		for (int k = 0; k < 9; k++)
			r[k] = wide ? $urandom() : COORD_W'($signed($urandom_range(64 * UNIT)) - 32 * UNIT);
		w = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], lst};
		return w;
	endfunction

	function automatic in_word_t uniform(input coord_t c, input bit lst);
		in_word_t w;
		w = {c, c, c, c, c, c, c, c, c, lst};
		return w;
	endfunction

	initial begin
		longint o[3], d[3];
		int blen, tris;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		ray_o = '{0, 0, 0};
		ray_d = '{0, 0, UNIT};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset ray, nearest-hit mode.
		send(aimed(5, 1'b0));
		send(uniform(C_MAX, 1'b0));
		send(uniform(C_MIN, 1'b0));
		send(uniform(C_ZERO, 1'b0));
		send(aimed(-3, 1'b0));
		send(aimed(2, 1'b1));
		send(noise(1'b1, 1'b1));
		settle();
		// First-hit mode: later triangles of the batch are skipped.
		cfg_write(CFG_FIRST_HIT_MODE, 32'd1);
		send(aimed(4, 1'b0));
		send(aimed(1, 1'b0));
		send(noise(1'b0, 1'b0));
		send(aimed(6, 1'b1));
		send(aimed(3, 1'b1));
		send(uniform(C_ZERO, 1'b1));
		settle();
		// Threshold extremes.
		cfg_write(CFG_FIRST_HIT_MODE, 32'd0);
		cfg_write(CFG_DET_THRESHOLD, 32'd0);
		send(uniform(C_ZERO, 1'b0));
		send(aimed(7, 1'b1));
		settle();
		cfg_write(CFG_DET_THRESHOLD, 32'h7FFF_FFFF);
		send(aimed(7, 1'b0));
		send(aimed(2, 1'b1));
		settle();
		cfg_write(CFG_DET_THRESHOLD, 32'd7);
		// Extreme ray registers.
		o = '{64'sd2147483647, -64'sd2147483648, 64'sd2147483647};
		d = '{-64'sd2147483648, 64'sd2147483647, -64'sd2147483648};
		set_ray(o, d);
		send(uniform(C_MAX, 1'b0));
		send(uniform(C_MIN, 1'b0));
		send(noise(1'b1, 1'b0));
		send(noise(1'b1, 1'b1));
		settle();

		// Index wrap: a long batch of flat triangles, then a hit at index zero.
		set_ray('{0, 0, -5 * UNIT}, '{0, 0, UNIT});
		quiet = 1'b1;
		for (int i = 0; i < MAX_TRIANGLES_DEF; i++) send(uniform(C_ZERO, 1'b0));
		send(aimed(6, 1'b1));
		quiet = 1'b0;
		settle();

		// Random phases with fresh rays and modes.
		tris = 0;
		for (int ph = 0; ph < 10; ph++) begin
			for (int k = 0; k < 3; k++) begin
				o[k] = $signed($urandom_range(40 * UNIT)) - 20 * UNIT;
				d[k] = $signed($urandom_range(UNIT)) - UNIT / 2;
			end
			d[$urandom_range(2)] = ($urandom_range(1) ? 1 : -1) * $urandom_range(4 * UNIT, UNIT);
			set_ray(o, d);
			cfg_write(CFG_FIRST_HIT_MODE, ph % 3 == 1);
			cfg_write(CFG_DET_THRESHOLD, (ph % 4 == 2) ? 32'd0 : $urandom_range(4 * UNIT));
			quiet = (ph == 4);
			for (int b = 0; b < 40; b++) begin
				blen = $urandom_range(8, 1);
				if (ph == 6 && b == 10) hold_req = 1'b1;
				for (int i = 0; i < blen; i++) begin
					int pick;
					pick = $urandom_range(99);
					if (pick < 65)
						send(aimed($signed($urandom_range(40)) - 8, i == blen - 1));
					else if (pick < 85)
						send(noise(1'b0, i == blen - 1));
					else
						send(noise(1'b1, i == blen - 1));
					tris++;
				end
			end
			quiet = 1'b0;
			settle();
		end

		$display("Sent %0d triangles (%0d in random batches), checked %0d reports.",
			sent, tris, reports);
		$display("Covered nearest and first-hit modes, threshold extremes, index wrap.");
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
